// ===== design/irt_pkg.sv =====
// Package for the interval range table: sizes, operation and status codes,
// the stored entry layout and the control bundle to the entry store.
// No dependencies.
`default_nettype none

package irt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SLOT_W  = 6;
  localparam int CMP_W   = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERLAP  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADRANGE = 3'd4;

  typedef struct packed {
    logic [31:0] ebegin;
    logic [31:0] elimit;
    logic [7:0]  ekind;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             del_en;
    logic [IDX_W-1:0] del_addr;
    logic             clr;
  } store_ctl_t;

endpackage

`default_nettype wire

// ===== design/irt_store.sv =====
// Entry store of the interval range table: one synchronous memory for the
// bounds and kinds, plus the per-slot used flags. Depends on irt_pkg.
`default_nettype none

module irt_store
  import irt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire store_ctl_t       ctl,
  input  wire entry_t           wr_data,
  input  wire logic [IDX_W-1:0] probe_addr,
  output logic                  probe_used,
  output entry_t                rd_data,
  output logic                  rd_used
);

  entry_t           mem [ENTRIES];
  logic [ENTRIES-1:0] used;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
      rd_used <= used[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      used <= '0;
    end else begin
      if (ctl.del_en) begin
        used[ctl.del_addr] <= 1'b0;
      end
      if (ctl.wr_en) begin
        used[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign probe_used = used[probe_addr];

endmodule

`default_nettype wire

// ===== design/interval_range_table_unit.sv =====
// Top level of the interval range table: command port, scan sequencer and
// result registers. Depends on irt_pkg and irt_store.
// Insert (legal range) and find run a scan that reads one stored entry per
// cycle from the entry memory; a hit or overlap ends the scan early. Delete,
// clear and a bad range finish without a scan.
// The result strobe done is high for one cycle after the transfer completes.
// Reset clears the used flags and the sequencer; the table is then empty.
`default_nettype none

module interval_range_table_unit
  import irt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] range_begin,
  input  wire logic [31:0] range_limit,
  input  wire logic [7:0]  kind,
  input  wire logic [5:0]  slot,
  input  wire logic [31:0] point,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       result_slot,
  output logic [7:0]       result_kind,
  output logic [31:0]      found_begin,
  output logic [31:0]      found_limit
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  function automatic logic [5:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(idx);
    return wide[5:0];
  endfunction

  state_t           state;
  logic [CNT_W-1:0] iss;
  logic             pv;
  logic [IDX_W-1:0] pidx;
  logic             have_free;
  logic [IDX_W-1:0] free_slot;
  logic [1:0]       op_q;
  logic [31:0]      beg_q;
  logic [31:0]      lim_q;
  logic [7:0]       kind_q;
  logic [31:0]      pt_q;

  store_ctl_t       ctl;
  entry_t           wr_data;
  entry_t           rd_data;
  logic             rd_used;
  logic             probe_used;

  logic             accept;
  logic [CMP_W-1:0] slot_ext;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic             issue;
  logic             ovl;
  logic             hit;
  logic             last;
  logic             room;
  logic [IDX_W-1:0] free_idx;
  logic             ins_op;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign slot_ext = CMP_W'(slot);
  assign slot_ok  = slot_ext < CMP_W'(ENTRIES);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign issue    = (state == S_SCAN) && (iss != CNT_W'(ENTRIES));
  assign ins_op   = (op_q == OP_INSERT);
  assign ovl      = rd_used && (lim_q > rd_data.ebegin) && (beg_q < rd_data.elimit);
  assign hit      = rd_used && (pt_q >= rd_data.ebegin) && (pt_q < rd_data.elimit);
  assign last     = (pidx == IDX_W'(ENTRIES - 1));
  assign room     = have_free || !rd_used;
  assign free_idx = have_free ? free_slot : pidx;

  always_comb begin
    ctl          = '0;
    ctl.rd_en    = issue;
    ctl.rd_addr  = iss[IDX_W-1:0];
    ctl.wr_en    = pv && ins_op && !ovl && last && room;
    ctl.wr_addr  = free_idx;
    ctl.del_en   = accept && (operation == OP_DELETE) && slot_ok && probe_used;
    ctl.del_addr = slot_idx;
    ctl.clr      = accept && (operation == OP_CLEAR);
    wr_data      = '{ebegin: beg_q, elimit: lim_q, ekind: kind_q};
  end

  irt_store u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .wr_data    (wr_data),
    .probe_addr (slot_idx),
    .probe_used (probe_used),
    .rd_data    (rd_data),
    .rd_used    (rd_used)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss       <= '0;
      pv        <= 1'b0;
      have_free <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      pv   <= issue;
      if (issue) begin
        iss <= iss + CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            iss       <= '0;
            have_free <= 1'b0;
            unique case (operation)
              OP_INSERT: begin
                if (range_begin > range_limit) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_FIND: begin
                state <= S_SCAN;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (pv) begin
            if (ins_op) begin
              if (!rd_used && !have_free) begin
                have_free <= 1'b1;
              end
              if (ovl || last) begin
                done  <= 1'b1;
                pv    <= 1'b0;
                state <= S_IDLE;
              end
            end else if (hit || last) begin
              done  <= 1'b1;
              pv    <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      beg_q  <= range_begin;
      lim_q  <= range_limit;
      kind_q <= kind;
      pt_q   <= point;
    end
    if (pv) begin
      pidx <= pidx + IDX_W'(1);
    end else begin
      pidx <= '0;
    end
    if ((state == S_SCAN) && pv && ins_op && !rd_used && !have_free) begin
      free_slot <= pidx;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && accept) begin
      result_slot <= '0;
      result_kind <= '0;
      found_begin <= '0;
      found_limit <= '0;
      unique case (operation)
        OP_INSERT: status <= ST_BADRANGE;
        OP_DELETE: status <= (slot_ok && probe_used) ? ST_OK : ST_NOTFOUND;
        default:   status <= ST_OK;
      endcase
    end else if ((state == S_SCAN) && pv) begin
      result_slot <= '0;
      result_kind <= '0;
      found_begin <= '0;
      found_limit <= '0;
      if (ins_op) begin
        if (ovl) begin
          status <= ST_OVERLAP;
        end else if (room) begin
          status      <= ST_OK;
          result_slot <= to_slot(free_idx);
        end else begin
          status <= ST_FULL;
        end
      end else if (hit) begin
        status      <= ST_OK;
        result_slot <= to_slot(pidx);
        result_kind <= rd_data.ekind;
        found_begin <= rd_data.ebegin;
        found_limit <= rd_data.elimit;
      end else begin
        status <= ST_NOTFOUND;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is still scanning");

  a_pv_scan: assert property (@(posedge clk) disable iff (rst)
    pv |-> (state == S_SCAN))
    else $error("read data marked valid outside a scan");

  a_bad_range: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_INSERT) && (range_begin > range_limit))
      |=> (done && (status == ST_BADRANGE)))
    else $error("bad range insert did not report at once");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((result_slot == 6'd0) && (found_begin == 32'd0)
      && (found_limit == 32'd0) && (result_kind == 8'd0)))
    else $error("failed operation returned nonzero fields");

  a_write_end: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |=> (done && (status == ST_OK)))
    else $error("entry written without a successful insert result");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for interval_range_table_unit: a directed sequence
// followed by random insert, fill, lookup, delete and clear traffic, checked by a scoreboard.
// Depends on irt_pkg and the interval_range_table_unit RTL.
`timescale 1ns / 100ps

module tb;
  import irt_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [7:0]  kind;
    logic [31:0] fbegin;
    logic [31:0] flimit;
  } response_t;

  class interval_table_tracker;
    bit          used [ENTRIES];
    logic [31:0] lo [ENTRIES];
    logic [31:0] hi [ENTRIES];
    logic [7:0]  tag [ENTRIES];
    response_t   pending_responses [$];
    int unsigned errors;

    function void note_command(logic [1:0] op, logic [31:0] rb, logic [31:0] rl,
                               logic [7:0] k, logic [5:0] s, logic [31:0] p);
      response_t r;
      int        free_idx;
      bit        clash;
      bit        hit;
      r.status = ST_OK;
      r.slot = '0;
      r.kind = '0;
      r.fbegin = '0;
      r.flimit = '0;
      case (op)
        OP_INSERT: begin
          free_idx = -1;
          clash = 1'b0;
          if (rb > rl) begin
            r.status = ST_BADRANGE;
          end else begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (used[i]) begin
                if (rl > lo[i] && rb < hi[i]) clash = 1'b1;
              end else if (free_idx < 0) begin
                free_idx = i;
              end
            end
            if (clash) begin
              r.status = ST_OVERLAP;
            end else if (free_idx < 0) begin
              r.status = ST_FULL;
            end else begin
              used[free_idx] = 1'b1;
              lo[free_idx] = rb;
              hi[free_idx] = rl;
              tag[free_idx] = k;
              r.slot = 6'(free_idx);
            end
          end
        end
        OP_DELETE: begin
          if (s < ENTRIES && used[s]) used[s] = 1'b0;
          else r.status = ST_NOTFOUND;
        end
        OP_FIND: begin
          hit = 1'b0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && used[i] && p >= lo[i] && p < hi[i]) begin
              hit = 1'b1;
              r.slot = 6'(i);
              r.kind = tag[i];
              r.fbegin = lo[i];
              r.flimit = hi[i];
            end
          end
          if (!hit) r.status = ST_NOTFOUND;
        end
        default: begin
          for (int i = 0; i < ENTRIES; i++) used[i] = 1'b0;
        end
      endcase
      pending_responses.push_back(r);
    endfunction

    function void check_response(response_t got);
      response_t want;
      if (pending_responses.size() == 0) begin
        $error("result strobe with no command outstanding");
        errors++;
        return;
      end
      want = pending_responses.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("result_slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $error("result_kind: expected 0x%0h, got 0x%0h", want.kind, got.kind);
        errors++;
      end
      if (got.fbegin !== want.fbegin) begin
        $error("found_begin: expected 0x%0h, got 0x%0h", want.fbegin, got.fbegin);
        errors++;
      end
      if (got.flimit !== want.flimit) begin
        $error("found_limit: expected 0x%0h, got 0x%0h", want.flimit, got.flimit);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = OP_INSERT;
  logic [31:0] range_begin = '0;
  logic [31:0] range_limit = '0;
  logic [7:0]  kind = '0;
  logic [5:0]  slot = '0;
  logic [31:0] point = '0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [5:0]  result_slot;
  logic [7:0]  result_kind;
  logic [31:0] found_begin;
  logic [31:0] found_limit;

  interval_table_tracker tracker = new();
  int unsigned issued = 0;
  bit          idle_on = 1'b1;

  interval_range_table_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .range_begin (range_begin),
    .range_limit (range_limit),
    .kind        (kind),
    .slot        (slot),
    .point       (point),
    .done        (done),
    .status      (status),
    .result_slot (result_slot),
    .result_kind (result_kind),
    .found_begin (found_begin),
    .found_limit (found_limit)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        tracker.check_response('{status, result_slot, result_kind, found_begin, found_limit});
      end
      if (start && !busy) begin
        tracker.note_command(operation, range_begin, range_limit, kind, slot, point);
      end
    end
  end

  task automatic send_command(input logic [1:0] op, input logic [31:0] rb,
                              input logic [31:0] rl, input logic [7:0] k,
                              input logic [5:0] s, input logic [31:0] p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    range_begin <= rb;
    range_limit <= rl;
    kind <= k;
    slot <= s;
    point <= p;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  task automatic insert_range(input logic [31:0] rb, input logic [31:0] rl);
    send_command(OP_INSERT, rb, rl, 8'($urandom), 6'($urandom), $urandom);
  endtask

  task automatic find_point(input logic [31:0] p);
    send_command(OP_FIND, $urandom, $urandom, 8'($urandom), 6'($urandom), p);
  endtask

  task automatic delete_slot(input logic [5:0] s);
    send_command(OP_DELETE, $urandom, $urandom, 8'($urandom), s, $urandom);
  endtask

  task automatic clear_table();
    send_command(OP_CLEAR, $urandom, $urandom, 8'($urandom), 6'($urandom), $urandom);
  endtask

  task automatic mixed_command(input logic [31:0] base);
    int unsigned pick;
    logic [31:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      b = $urandom_range(32'hFFFF_FFFF, 1);
      insert_range(b, $urandom_range(b - 1, 0));
    end else if (pick < 35) begin
      b = base + 16 * $urandom_range(0, 63);
      insert_range(b, b + $urandom_range(0, 24));
    end else if (pick < 70) begin
      find_point(base + $urandom_range(0, 1100));
    end else if (pick < 88) begin
      delete_slot(6'(pick[0] ? $urandom_range(0, 15) : $urandom_range(0, 63)));
    end else if (pick < 90) begin
      clear_table();
    end else begin
      send_command(2'($urandom), $urandom, $urandom, 8'($urandom), 6'($urandom), $urandom);
    end
  endtask

  task automatic fill_pass(input logic [31:0] base);
    int unsigned n;
    logic [31:0] b;
    n = ENTRIES + $urandom_range(1, 3);
    clear_table();
    for (int j = 0; j < n; j++) begin
      b = base + 32 * j + $urandom_range(0, 8);
      send_command(OP_INSERT, b, b + $urandom_range(0, 20), 8'($urandom), 6'($urandom),
                   $urandom);
    end
    repeat (10) find_point(base + $urandom_range(0, n * 32));
    repeat (4) delete_slot(6'($urandom));
    repeat (3) insert_range(base + $urandom_range(0, n * 32), base + n * 32 + 8);
    repeat (2) insert_range(base + n * 32 + 64, base + n * 32 + 64 + $urandom_range(0, 9));
  endtask

  initial begin
    logic [31:0] base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    find_point(32'h0);
    delete_slot(6'd0);
    delete_slot(6'd63);
    insert_range(32'd5, 32'd4);
    insert_range(32'hFFFF_FFFF, 32'h0);
    send_command(OP_INSERT, 32'd0, 32'd0, 8'h00, 6'h3F, 32'hFFFF_FFFF);
    find_point(32'd0);
    send_command(OP_INSERT, 32'd0, 32'd10, 8'hFF, 6'h00, 32'h0);
    insert_range(32'd5, 32'd5);
    send_command(OP_INSERT, 32'd10, 32'd20, 8'hA5, 6'h2A, 32'h5555_5555);
    find_point(32'd9);
    find_point(32'd10);
    find_point(32'd20);
    send_command(OP_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'h5A, 6'h15, 32'hAAAA_AAAA);
    find_point(32'hFFFF_FFFE);
    find_point(32'hFFFF_FFFF);
    insert_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    insert_range(32'h0, 32'hFFFF_FFFF);
    delete_slot(6'd1);
    delete_slot(6'd1);
    send_command(OP_INSERT, 32'd3, 32'd7, 8'h01, 6'h3F, 32'h0);
    clear_table();
    find_point(32'd15);
    clear_table();

    while (issued < 1550) begin
      base = ($urandom_range(0, 3) == 0) ? 32'h0 : ($urandom & 32'hFFFF_0000);
      idle_on = (issued < 1300) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        fill_pass(base);
      end else begin
        repeat (60) mixed_command(base);
      end
    end
    start <= 1'b0;

    while (tracker.pending_responses.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
design/irt_pkg.sv
design/irt_store.sv
design/interval_range_table_unit.sv
verif/tb.sv
